// ----- hw/rtl/pbbm_pkg.sv -----
// ----------------------------------------------------------------------------
// pbbm_pkg
// Shared types and constants of the power button and battery monitor.
// ----------------------------------------------------------------------------
package pbbm_pkg;

  localparam int unsigned MvWidth    = 16;
  localparam int unsigned TickWidth  = 32;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 3;
  // 9*v + sample + 5 fits in 20 bits
  localparam int unsigned SumWidth   = 20;
  // ceil(2^23 / 10): exact floor(x/10) for every x below 2^22
  localparam int unsigned Div10Shift = 23;
  localparam logic [SumWidth-1:0] Div10Magic = 20'hCCCCD;

  localparam logic [MvWidth-1:0]   LowThreshRst   = 16'd10500;
  localparam logic [MvWidth-1:0]   EmptyThreshRst = 16'd9500;
  localparam logic [MvWidth-1:0]   HystRst        = 16'd100;
  localparam logic [TickWidth-1:0] ShortHoldRst   = 32'd2000;
  localparam logic [TickWidth-1:0] LongHoldRst    = 32'd4000;
  localparam logic [MvWidth-1:0]   SmoothRst      = 16'd12000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_THRESH   = 3'd0,
    CFG_EMPTY_THRESH = 3'd1,
    CFG_HYST         = 3'd2,
    CFG_SHORT_HOLD   = 3'd3,
    CFG_LONG_HOLD    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BAT_OK    = 2'd0,
    BAT_LOW   = 2'd1,
    BAT_EMPTY = 2'd2
  } bat_state_e;

endpackage

// ----- hw/rtl/power_button_and_battery_monitor.sv -----
// ----------------------------------------------------------------------------
// power_button_and_battery_monitor
// Button hold detection, emergency stop latching and smoothed battery
// voltage supervision with ok/low/empty hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one update beat: button
//   level, raw voltage sample, uptime ticks and two clear bits. Output channel
//   (out_valid_o / out_stall_i) returns one result beat per update: sticky
//   shutdown flags, emergency stop and send flag, filtered voltage, state.
//   A beat is taken on a rising edge with valid high and stall low.
//   Throughput: one update per cycle unless the receiver stalls. The update
//   is registered on entry; the state registers double as the result
//   register, so the whole step (filter add, divide-by-10 multiply,
//   threshold compares) is one pass. When the receiver stalls, the result
//   holds and the entry register still takes one more beat; after that
//   in_stall_o rises until the result goes.
//   Reset (rst_ni low) restores all config registers and state: filtered
//   voltage 12000 mV, state ok, all latches clear, button hold armed.
//   Config writes (cfg_we_i) take effect on the same edge, no handshake.
// ----------------------------------------------------------------------------
module power_button_and_battery_monitor
  import pbbm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // update beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 button_down_i,
  input  logic [MvWidth-1:0]   voltage_sample_mv_i,
  input  logic [TickWidth-1:0] uptime_ticks_i,
  input  logic                 clear_stop_i,
  input  logic                 clear_send_flag_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 shutdown_request_o,
  output logic                 immediate_shutdown_o,
  output logic                 emergency_stop_o,
  output logic                 stop_send_flag_o,
  output logic [MvWidth-1:0]   filtered_mv_o,
  output logic [1:0]           battery_state_o
);

  // config registers
  logic [MvWidth-1:0]   low_thresh_q, empty_thresh_q, hyst_q;
  logic [TickWidth-1:0] short_hold_q, long_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thresh_q   <= LowThreshRst;
      empty_thresh_q <= EmptyThreshRst;
      hyst_q         <= HystRst;
      short_hold_q   <= ShortHoldRst;
      long_hold_q    <= LongHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LOW_THRESH:   low_thresh_q   <= cfg_wdata_i[MvWidth-1:0];
        CFG_EMPTY_THRESH: empty_thresh_q <= cfg_wdata_i[MvWidth-1:0];
        CFG_HYST:         hyst_q         <= cfg_wdata_i[MvWidth-1:0];
        CFG_SHORT_HOLD:   short_hold_q   <= cfg_wdata_i;
        CFG_LONG_HOLD:    long_hold_q    <= cfg_wdata_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Entry register
  // --------------------------------------------------------------------------
  logic                 in_vld_q;
  logic                 btn_q, clr_stop_q, clr_send_q;
  logic [MvWidth-1:0]   sample_q;
  logic [TickWidth-1:0] now_q;
  logic                 step_en;   // entry beat moves into the state/result
  logic                 in_take;

  assign step_en    = in_vld_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !step_en;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step_en) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      btn_q      <= button_down_i;
      sample_q   <= voltage_sample_mv_i;
      now_q      <= uptime_ticks_i;
      clr_stop_q <= clear_stop_i;
      clr_send_q <= clear_send_flag_i;
    end
  end

  // --------------------------------------------------------------------------
  // Step state; these registers are also the result payload
  // --------------------------------------------------------------------------
  logic                 init_hold_q, init_hold_d;
  logic                 press_q, press_d;
  logic [TickWidth-1:0] start_q, start_d;
  logic                 shut_q, shut_d;
  logic                 imm_q, imm_d;
  logic                 stop_q, stop_d;
  logic                 send_q, send_d;
  logic [MvWidth-1:0]   smooth_q, smooth_d;
  bat_state_e           mode_q, mode_d;
  logic                 out_vld_q, out_vld_d;

  // button and stop latches
  logic [TickWidth-1:0] held;
  assign held = now_q - start_q;  // wraps modulo 2^32

  always_comb begin
    init_hold_d = init_hold_q;
    press_d     = press_q;
    start_d     = start_q;
    imm_d       = imm_q;
    shut_d      = shut_q;
    // clear bits act before the press is evaluated
    stop_d      = stop_q && !clr_stop_q;
    send_d      = send_q && !clr_send_q;
    if (!btn_q) begin
      init_hold_d = 1'b0;
      press_d     = 1'b0;
      start_d     = '0;
    end else if (!init_hold_q) begin
      if (!press_q) begin
        press_d = 1'b1;
        start_d = now_q;
        stop_d  = 1'b1;
        send_d  = 1'b1;
      end else begin
        if (held > short_hold_q) shut_d = 1'b1;
        if (held > long_hold_q)  imm_d  = 1'b1;
      end
    end
    // empty at the start of a step requests shutdown
    if (mode_q == BAT_EMPTY) shut_d = 1'b1;
  end

  // smoothing: floor((9*v + sample + 5) / 10) via reciprocal multiply
  logic [SumWidth-1:0]   filt_sum;
  logic [2*SumWidth-1:0] filt_prod;

  assign filt_sum  = {1'b0, smooth_q, 3'b000} + {4'b0000, smooth_q}
                   + {4'b0000, sample_q} + SumWidth'(5);
  assign filt_prod = {{SumWidth{1'b0}}, filt_sum} * {{SumWidth{1'b0}}, Div10Magic};
  assign smooth_d  = filt_prod[Div10Shift +: MvWidth];

  // hysteresis bands in signed arithmetic wide enough not to wrap
  logic signed [MvWidth+1:0] v_s, low_dn, low_up, empty_dn;

  assign v_s      = $signed({2'b00, smooth_d});
  assign low_dn   = $signed({2'b00, low_thresh_q}) - $signed({2'b00, hyst_q});
  assign low_up   = $signed({2'b00, low_thresh_q}) + $signed({2'b00, hyst_q});
  assign empty_dn = $signed({2'b00, empty_thresh_q}) - $signed({2'b00, hyst_q});

  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      BAT_OK: begin
        if (v_s < low_dn) mode_d = BAT_LOW;
      end
      BAT_LOW: begin
        if (v_s > low_up)   mode_d = BAT_OK;
        if (v_s < empty_dn) mode_d = BAT_EMPTY;  // empty wins
      end
      BAT_EMPTY: mode_d = BAT_EMPTY;
      default:   mode_d = mode_q;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step_en) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_hold_q <= 1'b1;
      press_q     <= 1'b0;
      start_q     <= '0;
      shut_q      <= 1'b0;
      imm_q       <= 1'b0;
      stop_q      <= 1'b0;
      send_q      <= 1'b0;
      smooth_q    <= SmoothRst;
      mode_q      <= BAT_OK;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (step_en) begin
        init_hold_q <= init_hold_d;
        press_q     <= press_d;
        start_q     <= start_d;
        shut_q      <= shut_d;
        imm_q       <= imm_d;
        stop_q      <= stop_d;
        send_q      <= send_d;
        smooth_q    <= smooth_d;
        mode_q      <= mode_d;
      end
    end
  end

  assign out_valid_o          = out_vld_q;
  assign shutdown_request_o   = shut_q;
  assign immediate_shutdown_o = imm_q;
  assign emergency_stop_o     = stop_q;
  assign stop_send_flag_o     = send_q;
  assign filtered_mv_o        = smooth_q;
  assign battery_state_o      = mode_q;

endmodule

// ----- hw/rtl/pbbm_checker.sv -----
// ----------------------------------------------------------------------------
// pbbm_checker
// Port-level checks of the power button and battery monitor.
// ----------------------------------------------------------------------------
module pbbm_checker
  import pbbm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               shutdown_request_o,
  input logic               immediate_shutdown_o,
  input logic [MvWidth-1:0] filtered_mv_o,
  input logic [1:0]         battery_state_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_mv_o))
    else $error("stalled result beat changed");

  // sticky requests never drop once shown
  a_shut_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shutdown_request_o |=> shutdown_request_o)
    else $error("shutdown request dropped");

  a_imm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && immediate_shutdown_o |=> immediate_shutdown_o)
    else $error("immediate shutdown dropped");

  // empty is terminal until reset
  a_empty_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (battery_state_o == BAT_EMPTY) |=> battery_state_o == BAT_EMPTY)
    else $error("battery left empty state");

endmodule

bind power_button_and_battery_monitor pbbm_checker u_pbbm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .shutdown_request_o   (shutdown_request_o),
  .immediate_shutdown_o (immediate_shutdown_o),
  .filtered_mv_o        (filtered_mv_o),
  .battery_state_o      (battery_state_o)
);

// ----- test/power_button_and_battery_monitor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_button_and_battery_monitor_tb
// Drives update beats through the monitor and checks every result beat
// against an in-bench model of the button latches, the voltage filter and
// the ok/low/empty state machine, across several register settings.
// ----------------------------------------------------------------------------
module power_button_and_battery_monitor_tb;
  import pbbm_pkg::*;

  // Cycles without any beat or register write before the run is abandoned.
  localparam int StallLimit = 5000;

  typedef struct {
    logic                 button;
    logic [MvWidth-1:0]   sample;
    logic [TickWidth-1:0] ticks;
    logic                 clr_stop;
    logic                 clr_send;
  } update_t;

  typedef struct {
    logic               shutdown;
    logic               immediate;
    logic               estop;
    logic               send;
    logic [MvWidth-1:0] mv;
    logic [1:0]         state;
  } status_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CFG_LOW_THRESH;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 button_down_i = 1'b0;
  logic [MvWidth-1:0]   voltage_sample_mv_i = '0;
  logic [TickWidth-1:0] uptime_ticks_i = '0;
  logic                 clear_stop_i = 1'b0;
  logic                 clear_send_flag_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 shutdown_request_o;
  logic                 immediate_shutdown_o;
  logic                 emergency_stop_o;
  logic                 stop_send_flag_o;
  logic [MvWidth-1:0]   filtered_mv_o;
  logic [1:0]           battery_state_o;

  power_button_and_battery_monitor uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .button_down_i        (button_down_i),
    .voltage_sample_mv_i  (voltage_sample_mv_i),
    .uptime_ticks_i       (uptime_ticks_i),
    .clear_stop_i         (clear_stop_i),
    .clear_send_flag_i    (clear_send_flag_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .shutdown_request_o   (shutdown_request_o),
    .immediate_shutdown_o (immediate_shutdown_o),
    .emergency_stop_o     (emergency_stop_o),
    .stop_send_flag_o     (stop_send_flag_o),
    .filtered_mv_o        (filtered_mv_o),
    .battery_state_o      (battery_state_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model state: register copies plus the monitor's own latches
  // --------------------------------------------------------------------------
  logic [MvWidth-1:0]   low_mv      = LowThreshRst;
  logic [MvWidth-1:0]   empty_mv    = EmptyThreshRst;
  logic [MvWidth-1:0]   hyst_mv     = HystRst;
  logic [TickWidth-1:0] short_ticks = ShortHoldRst;
  logic [TickWidth-1:0] long_ticks  = LongHoldRst;

  logic                 hold_armed_n = 1'b1;  // set until first release
  logic                 pressing     = 1'b0;
  logic [TickWidth-1:0] press_t0     = '0;
  logic                 shutdown_q   = 1'b0;
  logic                 immediate_q  = 1'b0;
  logic                 estop_q      = 1'b0;
  logic                 send_q       = 1'b0;
  logic [MvWidth-1:0]   smooth_mv    = SmoothRst;
  bat_state_e           bat_q        = BAT_OK;

  update_t pending_updates[$];
  status_t expected_status[$];
  update_t on_wire;

  int send_pct = 15, recv_pct = 52;
  int updates_in = 0, results_seen = 0, mismatches = 0;
  int presses = 0, state_moves = 0;

  // One monitor step: clears, button, then filter and state machine.
  function automatic status_t monitor_step(update_t u);
    logic [TickWidth-1:0] held;
    int unsigned          acc;
    int                   v, lo, em, hy;
    status_t              s;
    bat_state_e           prev;

    if (u.clr_stop) estop_q = 1'b0;
    if (u.clr_send) send_q = 1'b0;

    if (!u.button) begin
      hold_armed_n = 1'b0;
      pressing     = 1'b0;
      press_t0     = '0;
    end else if (!hold_armed_n) begin
      if (!pressing) begin
        pressing = 1'b1;
        press_t0 = u.ticks;
        estop_q  = 1'b1;
        send_q   = 1'b1;
        presses++;
      end else begin
        held = u.ticks - press_t0;  // wraps mod 2^32
        if (held > short_ticks) shutdown_q = 1'b1;
        if (held > long_ticks) immediate_q = 1'b1;
      end
    end

    acc       = 9 * smooth_mv + u.sample + 5;
    smooth_mv = MvWidth'(acc / 10);
    v  = int'(smooth_mv);
    lo = int'(low_mv);
    em = int'(empty_mv);
    hy = int'(hyst_mv);
    prev = bat_q;
    case (bat_q)
      BAT_OK: begin
        if (v < lo - hy) bat_q = BAT_LOW;
      end
      BAT_LOW: begin
        if (v > lo + hy) bat_q = BAT_OK;
        if (v < em - hy) bat_q = BAT_EMPTY;
      end
      BAT_EMPTY: begin
        shutdown_q = 1'b1;
      end
      default: ;
    endcase
    if (bat_q != prev) state_moves++;

    s.shutdown  = shutdown_q;
    s.immediate = immediate_q;
    s.estop     = estop_q;
    s.send      = send_q;
    s.mv        = smooth_mv;
    s.state     = bat_q;
    return s;
  endfunction

  function automatic logic sender_pauses();
    return $urandom_range(0, 99) < send_pct;
  endfunction

  function automatic logic receiver_holds();
    return $urandom_range(0, 99) < recv_pct;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predicts on every taken update beat, keeps a stalled beat steady
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_status.push_back(monitor_step(on_wire));
        updates_in++;
      end
      if (in_valid_i && in_stall_o) begin
        // held beat, payload stays
      end else if (pending_updates.size() > 0 && !sender_pauses()) begin
        on_wire              = pending_updates.pop_front();
        button_down_i       <= on_wire.button;
        voltage_sample_mv_i <= on_wire.sample;
        uptime_ticks_i      <= on_wire.ticks;
        clear_stop_i        <= on_wire.clr_stop;
        clear_send_flag_i   <= on_wire.clr_send;
        in_valid_i          <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each taken result beat against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_status();
    status_t e;
    if (expected_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat %0d arrived with no update outstanding", results_seen);
    end else begin
      e = expected_status.pop_front();
      if (e.shutdown !== shutdown_request_o || e.immediate !== immediate_shutdown_o ||
          e.estop !== emergency_stop_o || e.send !== stop_send_flag_o ||
          e.mv !== filtered_mv_o || e.state !== battery_state_o) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp sd=%0b imm=%0b stop=%0b send=%0b mv=%0d st=%0d, %s",
                   results_seen, e.shutdown, e.immediate, e.estop, e.send, e.mv,
                   e.state, $sformatf("got sd=%0b imm=%0b stop=%0b send=%0b mv=%0d st=%0d",
                   shutdown_request_o, immediate_shutdown_o, emergency_stop_o,
                   stop_send_flag_o, filtered_mv_o, battery_state_o));
      end
    end
    results_seen++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_status();
      out_stall_i <= receiver_holds();
    end
  end

  // Watchdog: too long without any beat or write means the block hung.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_update(input logic btn, input logic [MvWidth-1:0] mv,
                            input logic [TickWidth-1:0] t, input logic cs,
                            input logic cf);
    update_t u;
    u.button   = btn;
    u.sample   = mv;
    u.ticks    = t;
    u.clr_stop = cs;
    u.clr_send = cf;
    pending_updates.push_back(u);
  endtask

  // Samples mostly sit near a threshold so the filtered value walks across
  // the hysteresis band; the rest are rail values or anything at all.
  function automatic logic [MvWidth-1:0] pick_sample();
    int r, base, span, c;
    r = $urandom_range(0, 9);
    if (r == 0) return MvWidth'($urandom_range(0, 65535));
    if (r == 1) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    base = $urandom_range(0, 1) ? int'(low_mv) : int'(empty_mv);
    span = int'(hyst_mv) + 600;
    c = base - span + int'($urandom_range(0, 2 * span));
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return MvWidth'(c);
  endfunction

  // Mostly release-press-hold sequences, often with hold steps that straddle
  // the configured hold times; the rest is unstructured noise.
  task automatic queue_random(input int count);
    int made, len, k;
    logic [TickWidth-1:0] t0, dt;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(2, 8);
        t0  = $urandom;
        case ($urandom_range(0, 3))
          0:       dt = $urandom;
          1:       dt = $urandom_range(0, 3);
          2:       dt = short_ticks / len + $urandom_range(0, 2);
          default: dt = long_ticks / len + $urandom_range(0, 2);
        endcase
        for (k = 0; k <= len; k++)
          add_update(k != 0, pick_sample(), t0 + dt * k,
                     $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
        made += len + 1;
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          add_update(1'($urandom_range(0, 1)), pick_sample(), $urandom,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made += len;
      end
    end
  endtask

  // Block until every queued beat went in and every result came back.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_updates.size() != 0 || in_valid_i || expected_status.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_LOW_THRESH:   low_mv      = data[MvWidth-1:0];
      CFG_EMPTY_THRESH: empty_mv    = data[MvWidth-1:0];
      CFG_HYST:         hyst_mv     = data[MvWidth-1:0];
      CFG_SHORT_HOLD:   short_ticks = data;
      CFG_LONG_HOLD:    long_ticks  = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] lo, input logic [15:0] em,
                               input logic [15:0] hy, input logic [31:0] sh,
                               input logic [31:0] lg);
    write_reg(CFG_LOW_THRESH, CfgDataW'(lo));
    write_reg(CFG_EMPTY_THRESH, CfgDataW'(em));
    write_reg(CFG_HYST, CfgDataW'(hy));
    write_reg(CFG_SHORT_HOLD, sh);
    write_reg(CFG_LONG_HOLD, lg);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  //   The shutdown latches and the empty state are sticky until reset, and
  //   reset happens once, so the settings are ordered: first hold times that
  //   can never be exceeded and an empty band that can never be reached,
  //   then finite hold times, and last a reachable empty state.
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings. Filter starts at 12000 mV.
    add_update(1'b1, 16'd12000, 32'd0, 1'b0, 1'b0);          // press during initial hold
    add_update(1'b1, 16'd12000, 32'd5000, 1'b1, 1'b1);       // still ignored, no hold test
    add_update(1'b0, 16'd0, 32'd100, 1'b0, 1'b0);            // first release arms button
    add_update(1'b1, 16'hFFFF, 32'hFFFF_FF00, 1'b1, 1'b1);   // clears then new press sets
    add_update(1'b1, 16'd12000, 32'h0000_0100, 1'b1, 1'b0);  // hold across tick wrap
    add_update(1'b1, 16'd12000, 32'h0000_06D0, 1'b0, 1'b1);  // held exactly short time
    add_update(1'b0, 16'd12000, 32'd0, 1'b0, 1'b0);
    repeat (4) add_update(1'b0, 16'd0, 32'd0, 1'b0, 1'b0);  // walk down into low
    add_update(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);   // back up to ok
    add_update(1'b1, 16'd12000, 32'hFFFF_FFFF, 1'b0, 1'b0);  // press at top tick
    add_update(1'b1, 16'd12000, 32'd0, 1'b1, 1'b1);          // clears while held
    add_update(1'b0, 16'hFFFF, 32'd0, 1'b0, 1'b0);
    wait_quiet();

    // Hold times unreachable, empty band below zero.
    load_settings(16'd11000, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(300);
    wait_quiet();

    // Rail settings: lower band edges at zero, upper edge above full scale.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(40);
    wait_quiet();

    // Finite hold times; sender now idles more than the receiver stalls.
    send_pct = 52;
    recv_pct = 15;
    load_settings(16'd14000, 16'd0, 16'd250, 32'd1500, 32'd6000);
    queue_random(250);
    wait_quiet();

    // Zero hold times and a reachable empty state, no idling at all.
    send_pct = 0;
    recv_pct = 0;
    load_settings(16'd12000, 16'd11000, 16'd150, 32'd0, 32'd0);
    queue_random(220);
    wait_quiet();

    $display("covered %0d updates, %0d new presses, %0d battery state changes",
             updates_in, presses, state_moves);
    $display("over 5 register settings; %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- power_button_and_battery_monitor.f -----
hw/rtl/pbbm_pkg.sv
hw/rtl/power_button_and_battery_monitor.sv
hw/rtl/pbbm_checker.sv
test/power_button_and_battery_monitor_tb.sv
